// ===== hw/rtl/kest_pkg.sv =====
// Shared types and constants for the keyed expiring slot table.
`timescale 1ns / 1ps
`default_nettype none

package kest_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);

    // Input word layout (s_tdata), lowest bit first
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 80;
    localparam int SLOT_W     = 5;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] expiry;
        logic [23:0] radius;
        logic [15:0] rate;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        HOW_KEY     = 2'd0,
        HOW_EXPIRED = 2'd1,
        HOW_EVICT   = 2'd2
    } how_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_DONE,
        S_TICK,
        S_READ,
        S_READ_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kest_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module kest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_expiring_slot_table.sv =====
// Top level: keyed expiring slot table with a sequenced scan over one entry RAM.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser opcode, s_tdata item fields
//  m_      | out | m_tvalid/m_tready  | m_tdata slot, how_found, key, radius, expiry
//
// Allocate scans the table one entry per cycle through the RAM read port and
// stops early on a key match. Tick streams every entry through one 16x16
// multiplier and a saturating subtract. Reset clears a valid bit per entry; an
// entry never allocated reads as zero. A stalled result is held in the output
// register while the next word is accepted; a finished item waits only if that
// register is full.
`timescale 1ns / 1ps
`default_nettype none

module keyed_expiring_slot_table (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // key[15:0], now_ms[47:16], elapsed_ms[63:48], expiry_ms[95:64],
    // initial_radius[119:96], decay_rate[135:120], read_slot[140:136], zero pad
    input  wire logic [143:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // slot[4:0], how_found[6:5], entry_key[22:7], entry_radius[46:23],
    // entry_expiry[78:47], zero pad
    output logic [79:0]       m_tdata
);

    localparam int N  = kest_pkg::NUM_ENTRIES;
    localparam int AW = kest_pkg::IDX_W;

    kest_pkg::state_t state_reg, state_next;

    // latched item
    logic [15:0] key_reg;
    logic [31:0] now_reg;
    logic [15:0] elapsed_reg;
    logic [31:0] expiry_reg;
    logic [23:0] radius_reg;
    logic [15:0] rate_reg;
    logic [4:0]  rslot_reg;

    // scan pipeline
    logic [AW:0]   issue_cnt_reg, issue_cnt_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          rdv_reg;
    logic          exp_found_reg, exp_found_next;
    logic [AW-1:0] exp_idx_reg, exp_idx_next;
    logic [AW-1:0] sel_idx_reg, sel_idx_next;
    kest_pkg::how_t how_reg, how_next;

    // tick write-back stage
    logic            wb_vld_reg, wb_vld_next;
    logic            wb_live_reg, wb_live_next;
    logic [AW-1:0]   wb_idx_reg, wb_idx_next;
    logic [31:0]     prod_reg, prod_next;
    kest_pkg::entry_t wb_entry_reg, wb_entry_next;

    logic [N-1:0] valid_reg;

    // output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [4:0]  o_slot_reg, o_slot_next;
    logic [1:0]  o_how_reg, o_how_next;
    logic [15:0] o_key_reg, o_key_next;
    logic [23:0] o_radius_reg, o_radius_next;
    logic [31:0] o_expiry_reg, o_expiry_next;

    // RAM port signals
    logic             rd_en, wr_en, set_valid;
    logic [AW-1:0]    rd_addr, wr_addr;
    kest_pkg::entry_t wr_data, ram_rdata, rd_entry;

    logic          accept, out_free, in_range, exp_hit;
    logic [AW-1:0] last_idx;

    assign s_tready = (state_reg == kest_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_range = (32'(rslot_reg) < 32'(N));
    assign last_idx = AW'(N - 1);
    assign rd_entry = rdv_reg ? ram_rdata : '0;
    assign exp_hit  = (rd_entry.expiry < now_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, o_expiry_reg, o_radius_reg, o_key_reg, o_how_reg, o_slot_reg};

    kest_ram #(
        .WIDTH(kest_pkg::ENTRY_W),
        .DEPTH(N)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = issue_cnt_reg[AW-1:0];
        exp_found_next = exp_found_reg;
        exp_idx_next   = exp_idx_reg;
        sel_idx_next   = sel_idx_reg;
        how_next       = how_reg;
        wb_vld_next    = 1'b0;
        wb_live_next   = wb_live_reg;
        wb_idx_next    = wb_idx_reg;
        prod_next      = prod_reg;
        wb_entry_next  = wb_entry_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_cnt_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = sel_idx_reg;
        wr_data        = '{key: key_reg, expiry: expiry_reg, radius: radius_reg, rate: rate_reg};
        set_valid      = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        o_slot_next    = o_slot_reg;
        o_how_next     = o_how_reg;
        o_key_next     = o_key_reg;
        o_radius_next  = o_radius_reg;
        o_expiry_next  = o_expiry_reg;

        // issue one read per cycle while scanning
        if ((state_reg == kest_pkg::S_ALLOC || state_reg == kest_pkg::S_TICK) &&
            (issue_cnt_reg < (AW+1)'(N))) begin
            rd_en          = 1'b1;
            chk_vld_next   = 1'b1;
            issue_cnt_next = issue_cnt_reg + 1'b1;
        end

        unique case (state_reg)
            kest_pkg::S_IDLE: begin
                issue_cnt_next = '0;
                exp_found_next = 1'b0;
                if (accept) begin
                    case (kest_pkg::op_t'(s_tuser))
                        kest_pkg::OP_ALLOC: state_next = kest_pkg::S_ALLOC;
                        kest_pkg::OP_TICK:  state_next = kest_pkg::S_TICK;
                        kest_pkg::OP_READ:  state_next = kest_pkg::S_READ;
                        default:            state_next = kest_pkg::S_IDLE;
                    endcase
                end
            end
            kest_pkg::S_ALLOC: begin
                if (chk_vld_reg) begin
                    if (key_reg != 16'd0 && rd_entry.key == key_reg) begin
                        sel_idx_next = chk_idx_reg;
                        how_next     = kest_pkg::HOW_KEY;
                        state_next   = kest_pkg::S_ALLOC_DONE;
                    end else begin
                        if (!exp_found_reg && exp_hit) begin
                            exp_found_next = 1'b1;
                            exp_idx_next   = chk_idx_reg;
                        end
                        if (chk_idx_reg == last_idx) begin
                            state_next = kest_pkg::S_ALLOC_DONE;
                            if (exp_found_reg) begin
                                sel_idx_next = exp_idx_reg;
                                how_next     = kest_pkg::HOW_EXPIRED;
                            end else if (exp_hit) begin
                                sel_idx_next = chk_idx_reg;
                                how_next     = kest_pkg::HOW_EXPIRED;
                            end else begin
                                sel_idx_next = '0;
                                how_next     = kest_pkg::HOW_EVICT;
                            end
                        end
                    end
                end
            end
            kest_pkg::S_ALLOC_DONE: begin
                if (out_free) begin
                    wr_en         = 1'b1;
                    set_valid     = 1'b1;
                    m_tvalid_next = 1'b1;
                    o_slot_next   = 5'(sel_idx_reg);
                    o_how_next    = how_reg;
                    o_key_next    = key_reg;
                    o_radius_next = radius_reg;
                    o_expiry_next = expiry_reg;
                    state_next    = kest_pkg::S_IDLE;
                end
            end
            kest_pkg::S_TICK: begin
                // stage 1: multiply, stage 2: saturating subtract and write back
                wb_vld_next   = chk_vld_reg;
                wb_idx_next   = chk_idx_reg;
                wb_live_next  = (rd_entry.expiry >= now_reg) && (rd_entry.radius != 24'd0);
                prod_next     = 32'(elapsed_reg) * 32'(rd_entry.rate);
                wb_entry_next = rd_entry;
                if (wb_vld_reg) begin
                    wr_addr = wb_idx_reg;
                    wr_data = wb_entry_reg;
                    if (prod_reg >= 32'(wb_entry_reg.radius)) begin
                        wr_data.radius = 24'd0;
                    end else begin
                        wr_data.radius = wb_entry_reg.radius - prod_reg[23:0];
                    end
                    wr_en = wb_live_reg;
                    if (wb_idx_reg == last_idx) begin
                        state_next = kest_pkg::S_IDLE;
                    end
                end
            end
            kest_pkg::S_READ: begin
                rd_en      = in_range;
                rd_addr    = AW'(rslot_reg);
                state_next = kest_pkg::S_READ_DONE;
            end
            kest_pkg::S_READ_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    o_slot_next   = rslot_reg;
                    o_how_next    = kest_pkg::HOW_KEY;
                    o_key_next    = in_range ? rd_entry.key : 16'd0;
                    o_radius_next = in_range ? rd_entry.radius : 24'd0;
                    o_expiry_next = in_range ? rd_entry.expiry : 32'd0;
                    state_next    = kest_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = kest_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kest_pkg::S_IDLE;
            chk_vld_reg   <= 1'b0;
            wb_vld_reg    <= 1'b0;
            exp_found_reg <= 1'b0;
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            issue_cnt_reg <= '0;
        end else begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            wb_vld_reg    <= wb_vld_next;
            exp_found_reg <= exp_found_next;
            m_tvalid_reg  <= m_tvalid_next;
            issue_cnt_reg <= issue_cnt_next;
            if (set_valid) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg     <= s_tdata[15:0];
            now_reg     <= s_tdata[47:16];
            elapsed_reg <= s_tdata[63:48];
            expiry_reg  <= s_tdata[95:64];
            radius_reg  <= s_tdata[119:96];
            rate_reg    <= s_tdata[135:120];
            rslot_reg   <= s_tdata[140:136];
        end
        if (rd_en) begin
            rdv_reg <= valid_reg[rd_addr];
        end
        chk_idx_reg  <= chk_idx_next;
        exp_idx_reg  <= exp_idx_next;
        sel_idx_reg  <= sel_idx_next;
        how_reg      <= how_next;
        wb_live_reg  <= wb_live_next;
        wb_idx_reg   <= wb_idx_next;
        prod_reg     <= prod_next;
        wb_entry_reg <= wb_entry_next;
        o_slot_reg   <= o_slot_next;
        o_how_reg    <= o_how_next;
        o_key_reg    <= o_key_next;
        o_radius_reg <= o_radius_next;
        o_expiry_reg <= o_expiry_next;
    end

endmodule

`default_nettype wire
